// File: rtl/core/xmf_pkg.sv
// XMODEM block framer: shared types, constants and the CRC-16 byte update.
// Used by the controller, the datapath and the top level. No dependencies.
`timescale 1ns / 1ps

package xmf_pkg;

  localparam logic       OP_DATA    = 1'b0;
  localparam logic       OP_END     = 1'b1;
  localparam logic [7:0] HDR_SOH    = 8'h01;
  localparam logic [7:0] PAD_BYTE   = 8'h1A;
  localparam logic [6:0] MAX_REPEAT = 7'd127;
  localparam logic [6:0] REPEAT_ONE = 7'd1;
  localparam logic [15:0] CRC_POLY  = 16'h1021;

  // source of the byte loaded into the output register
  typedef enum logic [2:0] {
    SEL_SOH,
    SEL_NUM,
    SEL_CMP,
    SEL_DATA,
    SEL_PAD1,
    SEL_PAD2,
    SEL_CRC_HI,
    SEL_TRL_LO
  } xmf_sel_t;

  typedef struct packed {
    logic     load_in;     // capture the input word
    logic     bn_inc;      // new block starts
    logic     bn_clr;      // end of data
    logic     emit;        // load output register
    xmf_sel_t sel;
    logic     last;
    logic     done;
    logic     take_data;   // fold data byte into sum/crc, count it
    logic     take_pad;    // fold one pad byte into sum/crc, count it
    logic     clear_block; // trailer sent
  } xmf_cmd_t;

  typedef struct packed {
    logic out_free;     // output register can take a word this cycle
    logic block_empty;  // no open block
    logic full_next;    // next byte fills the block
    logic pad_long;     // remaining pad exceeds one repeat run
    logic crc_mode;
    logic opcode;       // opcode on the input channel
  } xmf_stat_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/core/xmf_in_if.sv
// Input channel of the XMODEM block framer: valid/ready plus one input word.
// No dependencies.
`timescale 1ns / 1ps

interface xmf_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

// File: rtl/core/xmf_out_if.sv
// Output channel of the XMODEM block framer: valid/ready plus one framed word.
// No dependencies.
`timescale 1ns / 1ps

interface xmf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic [6:0] repeat_count;
  logic       block_done;
  logic       last_result;

  modport source (output valid, output byte_value, output repeat_count,
                  output block_done, output last_result, input ready);
  modport sink   (input valid, input byte_value, input repeat_count,
                  input block_done, input last_result, output ready);
endinterface

// File: rtl/core/xmf_datapath.sv
// Datapath of the XMODEM block framer: block state, checksum/CRC, pad sizing
// and the output register. Depends on xmf_pkg.
`timescale 1ns / 1ps

module xmf_datapath
  import xmf_pkg::*;
#(
  parameter int BLOCK_DATA_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       opcode,
  input  logic [7:0] data_byte,
  input  xmf_cmd_t   cmd,
  output xmf_stat_t  stat,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [7:0] byte_value,
  output logic [6:0] repeat_count,
  output logic       block_done,
  output logic       last_result
);

  localparam int CW = $clog2(BLOCK_DATA_BYTES);
  // pad arithmetic needs room for a full 7-bit repeat run
  localparam int PW = (CW + 1 > 8) ? CW + 1 : 8;
  localparam logic [CW-1:0] LAST_IDX = CW'(BLOCK_DATA_BYTES - 1);
  localparam logic [PW-1:0] BLK_LEN  = PW'(BLOCK_DATA_BYTES);
  localparam logic [PW-1:0] RUN_LEN  = PW'(MAX_REPEAT);

  logic          crc_mode;
  logic [7:0]    block_number;
  logic [CW-1:0] bytes_in_block;
  logic [7:0]    running_sum;
  logic [15:0]   running_crc;
  logic [7:0]    in_byte;

  logic [PW-1:0] pad_rem;
  logic [PW-1:0] pad_rem2;
  logic [6:0]    chunk1;
  logic [6:0]    chunk2;
  logic [7:0]    fold_byte;
  logic [7:0]    byte_next;
  logic [6:0]    repeat_next;

  assign pad_rem  = BLK_LEN - PW'(bytes_in_block);
  assign pad_rem2 = pad_rem - RUN_LEN;
  assign chunk1   = (pad_rem > RUN_LEN) ? MAX_REPEAT : pad_rem[6:0];
  assign chunk2   = (pad_rem2 > RUN_LEN) ? MAX_REPEAT : pad_rem2[6:0];

  assign fold_byte = cmd.take_pad ? PAD_BYTE : in_byte;

  always_comb begin
    repeat_next = REPEAT_ONE;
    unique case (cmd.sel)
      SEL_SOH:    byte_next = HDR_SOH;
      SEL_NUM:    byte_next = block_number;
      SEL_CMP:    byte_next = ~block_number;
      SEL_DATA:   byte_next = in_byte;
      SEL_PAD1: begin
        byte_next   = PAD_BYTE;
        repeat_next = chunk1;
      end
      SEL_PAD2: begin
        byte_next   = PAD_BYTE;
        repeat_next = chunk2;
      end
      SEL_CRC_HI: byte_next = running_crc[15:8];
      SEL_TRL_LO: byte_next = crc_mode ? running_crc[7:0] : running_sum;
      default:    byte_next = HDR_SOH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_mode       <= 1'b1;
      block_number   <= '0;
      bytes_in_block <= '0;
      running_sum    <= '0;
      running_crc    <= '0;
    end else begin
      if (cfg_we) begin
        crc_mode <= cfg_wdata;
      end
      if (cmd.bn_inc) begin
        block_number <= block_number + 8'd1;
      end else if (cmd.bn_clr) begin
        block_number <= '0;
      end
      if (cmd.clear_block) begin
        bytes_in_block <= '0;
        running_sum    <= '0;
        running_crc    <= '0;
      end else if (cmd.take_data || cmd.take_pad) begin
        bytes_in_block <= bytes_in_block + CW'(1);
        running_sum    <= running_sum + fold_byte;
        running_crc    <= crc16_byte(running_crc, fold_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_byte <= data_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      byte_value   <= byte_next;
      repeat_count <= repeat_next;
      block_done   <= cmd.done;
      last_result  <= cmd.last;
    end
  end

  assign stat.out_free    = !out_valid || out_ready;
  assign stat.block_empty = (bytes_in_block == '0);
  assign stat.full_next   = (bytes_in_block == LAST_IDX);
  assign stat.pad_long    = (pad_rem > RUN_LEN);
  assign stat.crc_mode    = crc_mode;
  assign stat.opcode      = opcode;

endmodule

// File: rtl/core/xmf_ctrl.sv
// Controller of the XMODEM block framer: sequences header, data, padding,
// pad folding and trailer words. Depends on xmf_pkg.
`timescale 1ns / 1ps

module xmf_ctrl
  import xmf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  xmf_stat_t stat,
  output xmf_cmd_t  cmd
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_SOH    = 10'b00_0000_0010,
    ST_NUM    = 10'b00_0000_0100,
    ST_CMP    = 10'b00_0000_1000,
    ST_DATA   = 10'b00_0001_0000,
    ST_PAD_A  = 10'b00_0010_0000,
    ST_PAD_B  = 10'b00_0100_0000,
    ST_FILL   = 10'b00_1000_0000,
    ST_TRL_HI = 10'b01_0000_0000,
    ST_TRL_LO = 10'b10_0000_0000
  } xmf_state_t;

  xmf_state_t state;
  xmf_state_t state_next;
  xmf_state_t trl_state;

  assign trl_state = stat.crc_mode ? ST_TRL_HI : ST_TRL_LO;

  always_comb begin
    cmd        = '0;
    cmd.sel    = SEL_SOH;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (stat.opcode == OP_DATA) begin
            if (stat.block_empty) begin
              cmd.bn_inc = 1'b1;
              state_next = ST_SOH;
            end else begin
              state_next = ST_DATA;
            end
          end else begin
            cmd.bn_clr = 1'b1;
            if (!stat.block_empty) begin
              state_next = ST_PAD_A;
            end
          end
        end
      end
      ST_SOH: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_SOH;
          state_next = ST_NUM;
        end
      end
      ST_NUM: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_NUM;
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_CMP;
          state_next = ST_DATA;
        end
      end
      ST_DATA: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.sel       = SEL_DATA;
          cmd.take_data = 1'b1;
          cmd.last      = !stat.full_next;
          state_next    = stat.full_next ? trl_state : ST_IDLE;
        end
      end
      ST_PAD_A: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_PAD1;
          state_next = stat.pad_long ? ST_PAD_B : ST_FILL;
        end
      end
      ST_PAD_B: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_PAD2;
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        // one pad byte folded into sum and crc per cycle
        cmd.take_pad = 1'b1;
        if (stat.full_next) begin
          state_next = trl_state;
        end
      end
      ST_TRL_HI: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_CRC_HI;
          state_next = ST_TRL_LO;
        end
      end
      ST_TRL_LO: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.sel         = SEL_TRL_LO;
          cmd.done        = 1'b1;
          cmd.last        = 1'b1;
          cmd.clear_block = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/core/xmodem_block_framer.sv
// XMODEM block framer. Takes one input word at a time and returns to accepting
// only when every framed word it causes has been loaded into the output
// register. A data byte is accepted, then loaded as a data word; the first byte of a
// block adds 3 header words, and the byte that fills a block adds 1 trailer
// word in checksum mode or 2 in CRC mode. An end-of-data word with no open
// block is only accepted; otherwise it is followed by 1 or 2 pad words, then the
// pad bytes are folded into the sum and CRC one byte per cycle, then the trailer.
// Backpressure on the output delays each word load while a loaded word waits
// on out_ch.ready. crc_mode resets to 1 (CRC-16) and may be written whenever
// the framer is idle.
`timescale 1ns / 1ps

module xmodem_block_framer
  import xmf_pkg::*;
#(
  parameter int BLOCK_DATA_BYTES = 128
) (
  input  logic clk,
  input  logic rst,
  xmf_in_if.sink    in_ch,
  xmf_out_if.source out_ch,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  xmf_cmd_t  cmd;
  xmf_stat_t stat;

  xmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  xmf_datapath #(
    .BLOCK_DATA_BYTES (BLOCK_DATA_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .opcode       (in_ch.opcode),
    .data_byte    (in_ch.data_byte),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .byte_value   (out_ch.byte_value),
    .repeat_count (out_ch.repeat_count),
    .block_done   (out_ch.block_done),
    .last_result  (out_ch.last_result)
  );

  // a data word always produces output, so the framer goes busy
  a_data_busy: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready && in_ch.opcode == OP_DATA |=> !in_ch.ready)
    else $error("framer ready right after taking a data word");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.block_done |-> out_ch.last_result)
    else $error("block trailer not flagged as last word");

  a_repeat_pad: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.repeat_count != REPEAT_ONE |-> out_ch.byte_value == PAD_BYTE)
    else $error("repeat run on a non-pad word");

  a_repeat_nz: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.repeat_count != 7'd0)
    else $error("zero repeat count");

endmodule
